// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ETF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define ETF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ETF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define ETF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== sv/etf_pkg.sv =====
`timescale 1ns / 1ps

package etf_pkg;

    localparam int FRAC_BITS = 28;
    localparam int MAX_SIDE  = 4096;

    localparam int COORD_W = 32;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int IDX_W   = 12;
    localparam int ITER_W  = 16;
    localparam int GAIN_W  = 8;
    localparam int NUM_W   = ITER_W + GAIN_W;
    localparam int LANES   = 3;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 72;

    localparam int CTRL_JULIA_BIT = 0;
    localparam int CTRL_GRAY_BIT  = 1;

    localparam logic [1:0]        RST_CONTROL   = 2'd0;
    localparam logic [ITER_W-1:0] RST_MAX_ITER  = 16'd200;
    localparam logic [31:0]       RST_ORIGIN_RE = 32'hE000_0000;
    localparam logic [31:0]       RST_ORIGIN_IM = 32'h2000_0000;
    localparam logic [30:0]       RST_STEP      = 31'd1073742;
    localparam logic [31:0]       RST_JULIA_RE  = 32'hF333_3333;
    localparam logic [31:0]       RST_JULIA_IM  = 32'd41875931;
    localparam logic [23:0]       RST_GAINS     = 24'd655873;

    localparam logic [GAIN_W-1:0] GRAY_GAIN = 8'd255;

    localparam logic signed [PROD_W-1:0] ESC_LIMIT = 64'sd4 <<< FRAC_BITS;
    localparam logic signed [PROD_W-1:0] SAT_MAX   = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_MIN   = -64'sd2147483648;

    typedef enum logic [CIDX_W-1:0] {
        REG_CONTROL   = 3'd0,
        REG_MAX_ITER  = 3'd1,
        REG_ORIGIN_RE = 3'd2,
        REG_ORIGIN_IM = 3'd3,
        REG_STEP      = 3'd4,
        REG_JULIA_RE  = 3'd5,
        REG_JULIA_IM  = 3'd6,
        REG_GAINS     = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COORD_MUL,
        ST_COORD_ADD,
        ST_MUL,
        ST_CHECK,
        ST_COLOR_MUL,
        ST_DIV_START,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]        control;
        logic [ITER_W-1:0] max_iter;
        logic [31:0]       origin_re;
        logic [31:0]       origin_im;
        logic [30:0]       step;
        logic [31:0]       julia_re;
        logic [31:0]       julia_im;
        logic [23:0]       gains;
    } cfg_t;

    typedef struct packed {
        logic [LANES-1:0][COORD_W-1:0] a;
        logic [LANES-1:0][COORD_W-1:0] b;
    } mul_op_t;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[COORD_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/etf_cfg.sv =====
`timescale 1ns / 1ps

module etf_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [etf_pkg::CIDX_W-1:0] cfg_index,
    input  logic [etf_pkg::CFG_W-1:0]  cfg_wdata,
    output etf_pkg::cfg_t            cfg
);
    import etf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control   <= RST_CONTROL;
            cfg_reg.max_iter  <= RST_MAX_ITER;
            cfg_reg.origin_re <= RST_ORIGIN_RE;
            cfg_reg.origin_im <= RST_ORIGIN_IM;
            cfg_reg.step      <= RST_STEP;
            cfg_reg.julia_re  <= RST_JULIA_RE;
            cfg_reg.julia_im  <= RST_JULIA_IM;
            cfg_reg.gains     <= RST_GAINS;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_CONTROL:   cfg_reg.control   <= cfg_wdata[1:0];
                REG_MAX_ITER:  cfg_reg.max_iter  <= cfg_wdata[ITER_W-1:0];
                REG_ORIGIN_RE: cfg_reg.origin_re <= cfg_wdata;
                REG_ORIGIN_IM: cfg_reg.origin_im <= cfg_wdata;
                REG_STEP:      cfg_reg.step      <= cfg_wdata[30:0];
                REG_JULIA_RE:  cfg_reg.julia_re  <= cfg_wdata;
                REG_JULIA_IM:  cfg_reg.julia_im  <= cfg_wdata;
                REG_GAINS:     cfg_reg.gains     <= cfg_wdata[23:0];
                default:       cfg_reg.control   <= cfg_reg.control;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/etf_mul.sv =====
`timescale 1ns / 1ps

// Three signed 32x32 multipliers with registered products, shared by the
// coordinate setup, the z^2 iteration and the color scaling.
module etf_mul (
    input  logic                                              clk,
    input  etf_pkg::mul_op_t                                  op,
    output logic [etf_pkg::LANES-1:0][etf_pkg::PROD_W-1:0]    prod
);
    import etf_pkg::*;

    logic [LANES-1:0][PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod_reg[i] <= PROD_W'($signed(op.a[i]) * $signed(op.b[i]));
        end
    end

    assign prod = prod_reg;

endmodule

// ===== sv/etf_div.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle, three lanes sharing a divisor.
// Quotient must fit GAIN_W bits (dividend < divisor << GAIN_W).
module etf_div (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            start,
    input  logic [etf_pkg::LANES-1:0][etf_pkg::NUM_W-1:0]   dividend,
    input  logic [etf_pkg::ITER_W-1:0]                      divisor,
    output logic [etf_pkg::LANES-1:0][etf_pkg::GAIN_W-1:0]  quotient,
    output logic                                            busy
);
    import etf_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W + 1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(GAIN_W);

    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [LANES-1:0][ITER_W-1:0]      rem_reg, rem_next;
    logic [LANES-1:0][GAIN_W-1:0]      quo_reg, quo_next;
    logic [LANES-1:0][ITER_W:0]        trial;
    logic [LANES-1:0]                  ge;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {rem_reg[i], quo_reg[i][GAIN_W-1]};
            ge[i]    = trial[i] >= {1'b0, divisor};
            if (start)
            begin
                rem_next[i] = dividend[i][NUM_W-1:GAIN_W];
                quo_next[i] = dividend[i][GAIN_W-1:0];
            end
            else if (cnt_reg != '0)
            begin
                rem_next[i] = ge[i] ? ITER_W'(trial[i] - {1'b0, divisor})
                                    : trial[i][ITER_W-1:0];
                quo_next[i] = {quo_reg[i][GAIN_W-2:0], ge[i]};
            end
            else
            begin
                rem_next[i] = rem_reg[i];
                quo_next[i] = quo_reg[i];
            end
        end
        if (start)
        begin
            cnt_next = DIV_STEPS;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign busy     = (cnt_reg != '0);

    `ETF_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= DIV_STEPS, "div count out of range")
    `ETF_ASSERT_NXT(a_cnt_step, clk, rst_n, cnt_reg != '0 && !start, cnt_reg == $past(cnt_reg) - CNT_W'(1), "div count skipped")

endmodule

// ===== sv/escape_time_fractal_pixel_top.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Escape-time fractal pixel engine (Mandelbrot / Julia).
// Input beat on s_axis: one pixel column and row. Output beat on m_axis: the
// pixel echoed back with its iteration count, inside flag and color bytes.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// do so only while no pixel is in flight, as the block does not enforce it;
// writes take effect on the next clock edge. One pixel is worked at a time:
// s_axis_tready is high only while the engine is idle. A single set of three
// 32x32 multipliers is reused for setup, for each z = z^2 + c step and for
// color scaling; each iteration runs a multiply state, then an escape test
// and update state. Color is divided by the iteration limit in a bit-serial
// divider with 8 quotient steps. The result sits in an output register: the
// next pixel is accepted while it waits, and a stalled m_axis only holds the
// engine once a second result is ready. Reset clears the handshake state and
// loads register defaults.
module escape_time_fractal_pixel_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [etf_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [etf_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // column [11:0], row [23:12]
    input  logic [etf_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_column [11:0], out_row [23:12], iteration_count [39:24],
    // inside_res [40], red [48:41], green [56:49], blue [64:57], zero [71:65]
    output logic [etf_pkg::OUT_W-1:0]   m_axis_tdata
);
    import etf_pkg::*;

    localparam logic [16:0] SIDE_LAST = 17'(MAX_SIDE - 1);

    cfg_t cfg;
    mul_op_t mul_op;
    logic [LANES-1:0][PROD_W-1:0] prod;
    logic [LANES-1:0][NUM_W-1:0]  dividend;
    logic [LANES-1:0][GAIN_W-1:0] quotient;
    logic div_busy;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   col_reg, row_reg, ci_reg, ri_reg;
    logic [COORD_W-1:0] x_reg, y_reg, c_re_reg, c_im_reg;
    logic [ITER_W-1:0]  k_reg;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg;

    logic in_ready, div_start, out_load, out_free;
    logic signed [PROD_W-1:0] xx, yy, xy_sh, mag, c_re_w, c_im_w;
    logic [COORD_W-1:0] x0, y0, nx, ny;
    logic esc, iter_go, in_set;
    logic [ITER_W-1:0] lk;
    logic [LANES-1:0][GAIN_W-1:0] gain;
    logic [IDX_W-1:0] ci_sat, ri_sat;
    logic [GAIN_W-1:0] red, green, blue;

    etf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    etf_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .prod (prod)
    );

    etf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (cfg.max_iter),
        .quotient (quotient),
        .busy     (div_busy)
    );

    // index clamp for the coordinate only
    assign ci_sat = ({5'b0, s_axis_tdata[IDX_W-1:0]} > SIDE_LAST) ? SIDE_LAST[IDX_W-1:0]
                                                                  : s_axis_tdata[IDX_W-1:0];
    assign ri_sat = ({5'b0, s_axis_tdata[2*IDX_W-1:IDX_W]} > SIDE_LAST)
                    ? SIDE_LAST[IDX_W-1:0] : s_axis_tdata[2*IDX_W-1:IDX_W];

    // start point from the registered column/row products
    assign x0 = sat32(PROD_W'($signed(cfg.origin_re)) + $signed(prod[0]));
    assign y0 = sat32(PROD_W'($signed(cfg.origin_im)) - $signed(prod[1]));

    // escape test and next z; xx, yy are floor-scaled squares
    assign xx     = $signed(prod[0]) >>> FRAC_BITS;
    assign yy     = $signed(prod[1]) >>> FRAC_BITS;
    assign xy_sh  = $signed(prod[2]) >>> (FRAC_BITS - 1);
    assign mag    = xx + yy;
    assign esc    = (mag >= ESC_LIMIT);
    assign iter_go = (k_reg != cfg.max_iter) && !esc;
    assign c_re_w = PROD_W'($signed(c_re_reg));
    assign c_im_w = PROD_W'($signed(c_im_reg));
    assign nx     = sat32(xx - yy + c_re_w);
    assign ny     = sat32(xy_sh + c_im_w);

    assign lk = cfg.max_iter - k_reg;

    always_comb
    begin
        if (cfg.control[CTRL_GRAY_BIT])
        begin
            gain[0] = GRAY_GAIN;
            gain[1] = '0;
            gain[2] = '0;
        end
        else
        begin
            gain[0] = cfg.gains[GAIN_W-1:0];
            gain[1] = cfg.gains[2*GAIN_W-1:GAIN_W];
            gain[2] = cfg.gains[3*GAIN_W-1:2*GAIN_W];
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            dividend[i] = prod[i][NUM_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_COORD_MUL:
            begin
                mul_op.a[0] = COORD_W'(ci_reg);
                mul_op.b[0] = COORD_W'(cfg.step);
                mul_op.a[1] = COORD_W'(ri_reg);
                mul_op.b[1] = COORD_W'(cfg.step);
                mul_op.a[2] = '0;
                mul_op.b[2] = '0;
            end
            ST_COLOR_MUL:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    mul_op.a[i] = COORD_W'(lk);
                    mul_op.b[i] = COORD_W'(gain[i]);
                end
            end
            default:
            begin
                mul_op.a[0] = x_reg;
                mul_op.b[0] = x_reg;
                mul_op.a[1] = y_reg;
                mul_op.b[1] = y_reg;
                mul_op.a[2] = x_reg;
                mul_op.b[2] = y_reg;
            end
        endcase
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    // next state
    always_comb
    begin
        case (state_reg)
            ST_IDLE:      state_next = s_axis_tvalid ? ST_COORD_MUL : ST_IDLE;
            ST_COORD_MUL: state_next = ST_COORD_ADD;
            ST_COORD_ADD: state_next = ST_MUL;
            ST_MUL:       state_next = ST_CHECK;
            ST_CHECK:     state_next = iter_go ? ST_MUL : ST_COLOR_MUL;
            ST_COLOR_MUL: state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:       state_next = div_busy ? ST_DIV : ST_OUT;
            ST_OUT:       state_next = out_free ? ST_IDLE : ST_OUT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // state decode
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:      in_ready  = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            ST_OUT:       out_load  = out_free;
            default:      in_ready  = 1'b0;
        endcase
    end

    assign in_set = (k_reg == cfg.max_iter);
    assign red    = in_set ? '0 : quotient[0];
    assign green  = in_set ? '0 : quotient[1];
    assign blue   = in_set ? '0 : quotient[2];

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
        begin
            col_reg <= s_axis_tdata[IDX_W-1:0];
            row_reg <= s_axis_tdata[2*IDX_W-1:IDX_W];
            ci_reg  <= ci_sat;
            ri_reg  <= ri_sat;
        end
        if (state_reg == ST_COORD_ADD)
        begin
            x_reg    <= x0;
            y_reg    <= y0;
            c_re_reg <= cfg.control[CTRL_JULIA_BIT] ? cfg.julia_re : x0;
            c_im_reg <= cfg.control[CTRL_JULIA_BIT] ? cfg.julia_im : y0;
            k_reg    <= '0;
        end
        else if (state_reg == ST_CHECK && iter_go)
        begin
            x_reg <= nx;
            y_reg <= ny;
            k_reg <= k_reg + ITER_W'(1);
        end
        if (out_load)
        begin
            out_data_reg <= {7'b0, blue, green, red, in_set, k_reg, row_reg, col_reg};
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `ETF_ASSERT_IMP(a_k_bound, clk, rst_n, state_reg == ST_CHECK, k_reg <= cfg.max_iter, "iteration count passed limit")
    `ETF_ASSERT_NXT(a_accept_start, clk, rst_n, s_axis_tvalid && s_axis_tready, state_reg == ST_COORD_MUL, "accepted beat did not start setup")
    `ETF_ASSERT_IMP(a_div_window, clk, rst_n, div_busy, state_reg == ST_DIV, "divider busy outside divide state")
    `ETF_ASSERT_NXT(a_load_shows, clk, rst_n, out_load, m_axis_tvalid && state_reg == ST_IDLE, "result load did not present beat")

endmodule

// ===== test/escape_time_fractal_pixel_checker.sv =====
`timescale 1ns / 1ps

// Watches the config port and both streams, computes each pixel's expected
// result at input acceptance and compares output beats in order.
module escape_time_fractal_pixel_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [etf_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [etf_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    // column [11:0], row [23:12]
    input  logic [etf_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_column [11:0], out_row [23:12], iteration_count [39:24],
    // inside_res [40], red [48:41], green [56:49], blue [64:57], zero [71:65]
    input  logic [etf_pkg::OUT_W-1:0]   m_axis_tdata,
    output int                          pixels_pending,
    output int                          fail_count
);

    import etf_pkg::*;

    // MSB first, so the struct lines up with the low bits of m_axis_tdata
    typedef struct packed {
        logic [GAIN_W-1:0] blue;
        logic [GAIN_W-1:0] green;
        logic [GAIN_W-1:0] red;
        logic              in_set;
        logic [ITER_W-1:0] iterations;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  column;
    } pixel_t;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    logic [1:0]         mode_r;
    logic [ITER_W-1:0]  limit_r;
    logic signed [31:0] org_re_r;
    logic signed [31:0] org_im_r;
    logic [30:0]        pitch_r;
    logic signed [31:0] jc_re_r;
    logic signed [31:0] jc_im_r;
    logic [23:0]        gains_r;

    pixel_t expected_pixels[$];

    function automatic longint clip_q(input longint v);
        longint r;
        r = v;
        if (v > Q_MAX)
            r = Q_MAX;
        else if (v < Q_MIN)
            r = Q_MIN;
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] shade(input int unsigned lim, input int unsigned k,
                                                input int unsigned gain);
        int unsigned level;
        level = ((lim - k) * gain) / lim;
        return level[GAIN_W-1:0];
    endfunction

    function automatic pixel_t escape_pixel(input logic [IDX_W-1:0] col,
                                            input logic [IDX_W-1:0] row);
        pixel_t res;
        longint x, y, xx, yy, nx, ny, cr, cim, pc, pr, radius_sq;
        int unsigned k, lim;
        radius_sq = 64'sd4 <<< FRAC_BITS;
        pc = col;
        pr = row;
        if (pc > MAX_SIDE - 1)
            pc = MAX_SIDE - 1;
        if (pr > MAX_SIDE - 1)
            pr = MAX_SIDE - 1;
        x = clip_q(longint'(org_re_r) + pc * longint'(pitch_r));
        y = clip_q(longint'(org_im_r) - pr * longint'(pitch_r));
        if (mode_r[CTRL_JULIA_BIT])
        begin
            cr  = longint'(jc_re_r);
            cim = longint'(jc_im_r);
        end
        else
        begin
            cr  = x;
            cim = y;
        end
        xx = (x * x) >>> FRAC_BITS;
        yy = (y * y) >>> FRAC_BITS;
        k = 0;
        lim = limit_r;
        while (k < lim && xx + yy < radius_sq)
        begin
            // 2xy: shift by one less
            ny = clip_q(((x * y) >>> (FRAC_BITS - 1)) + cim);
            nx = clip_q(xx - yy + cr);
            x = nx;
            y = ny;
            xx = (x * x) >>> FRAC_BITS;
            yy = (y * y) >>> FRAC_BITS;
            k++;
        end
        res = '0;
        res.column = col;
        res.row = row;
        res.iterations = k[ITER_W-1:0];
        res.in_set = (k == lim);
        if (!res.in_set)
        begin
            if (mode_r[CTRL_GRAY_BIT])
                res.red = shade(lim, k, GRAY_GAIN);
            else
            begin
                res.red   = shade(lim, k, gains_r[7:0]);
                res.green = shade(lim, k, gains_r[15:8]);
                res.blue  = shade(lim, k, gains_r[23:16]);
            end
        end
        return res;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t want;
        pixel_t got;
        if (!rst_n)
        begin
            mode_r   = RST_CONTROL;
            limit_r  = RST_MAX_ITER;
            org_re_r = RST_ORIGIN_RE;
            org_im_r = RST_ORIGIN_IM;
            pitch_r  = RST_STEP;
            jc_re_r  = RST_JULIA_RE;
            jc_im_r  = RST_JULIA_IM;
            gains_r  = RST_GAINS;
            expected_pixels.delete();
            pixels_pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CONTROL:   mode_r   = cfg_wdata[1:0];
                    REG_MAX_ITER:  limit_r  = cfg_wdata[ITER_W-1:0];
                    REG_ORIGIN_RE: org_re_r = cfg_wdata;
                    REG_ORIGIN_IM: org_im_r = cfg_wdata;
                    REG_STEP:      pitch_r  = cfg_wdata[30:0];
                    REG_JULIA_RE:  jc_re_r  = cfg_wdata;
                    REG_JULIA_IM:  jc_im_r  = cfg_wdata;
                    REG_GAINS:     gains_r  = cfg_wdata[23:0];
                    default: ;
                endcase
            end
            // output first: a beat leaving now can never be the one entering now
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(pixel_t)-1:0];
                if (expected_pixels.size() == 0)
                begin
                    $error("result beat with nothing expected: column %0d row %0d",
                           got.column, got.row);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("out_column", want.column, got.column);
                    check_field("out_row", want.row, got.row);
                    check_field("iteration_count", want.iterations, got.iterations);
                    check_field("inside_res", want.in_set, got.in_set);
                    check_field("red", want.red, got.red);
                    check_field("green", want.green, got.green);
                    check_field("blue", want.blue, got.blue);
                    check_field("zero", 0, m_axis_tdata >> $bits(pixel_t));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(escape_pixel(s_axis_tdata[IDX_W-1:0],
                                                       s_axis_tdata[2*IDX_W-1:IDX_W]));
            pixels_pending = expected_pixels.size();
        end
    end

endmodule

// ===== test/escape_time_fractal_pixel_top_tb.sv =====
`timescale 1ns / 1ps

module escape_time_fractal_pixel_top_tb;

    import etf_pkg::*;

    localparam int TIMEOUT_CYCLES = 5000000;
    localparam int RANDOM_PIXELS  = 1750;
    localparam int LONG_HOLD      = 3000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int Q_ONE          = 268435456;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;

    int     pixels_pending;
    int     fail_count;
    bit     quiet = 1'b0;
    bit     hold_req = 1'b0;
    longint cycle_count;

    escape_time_fractal_pixel_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    escape_time_fractal_pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .pixels_pending (pixels_pending),
        .fail_count     (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("escape_time_fractal_pixel_top test failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin : sink
        int gap;
        gap = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                gap--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!quiet)
                    gap = pick_gap();
            end
        end
    end

    // called at a falling edge; leaves cfg_we high for the next write
    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic load_config(input logic [1:0] ctl, input logic [ITER_W-1:0] lim,
                               input logic [31:0] ore, input logic [31:0] oim,
                               input logic [30:0] stp, input logic [31:0] jre,
                               input logic [31:0] jim, input logic [23:0] gns);
        put_reg(REG_CONTROL, ctl);
        put_reg(REG_MAX_ITER, lim);
        put_reg(REG_ORIGIN_RE, ore);
        put_reg(REG_ORIGIN_IM, oim);
        put_reg(REG_STEP, stp);
        put_reg(REG_JULIA_RE, jre);
        put_reg(REG_JULIA_IM, jim);
        put_reg(REG_GAINS, gns);
        cfg_we <= 1'b0;
    endtask

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        int g;
        g = quiet ? 0 : pick_gap();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, col};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pixels_pending != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int          sent;
        int          phase;
        int          kind;
        int          pick;
        int          count;
        int          span;
        logic [1:0]  ctl;
        logic [15:0] lim;
        logic [31:0] ore;
        logic [31:0] oim;
        logic [30:0] stp;
        logic [31:0] jre;
        logic [31:0] jim;
        logic [23:0] gns;
        logic [11:0] col;
        logic [11:0] row;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CONTROL;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults; (4095,4095) saturates the start point
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd500, 12'd500);
        settle();

        // Julia, grayscale
        load_config(2'd3, 16'd200, 32'hE000_0000, 32'h2000_0000, 31'd1073742,
                    32'hF333_3333, 32'd41875931, 24'd655873);
        send_pixel(12'd500, 12'd500);
        send_pixel(12'd123, 12'd456);
        settle();

        // Julia, color, full gains
        load_config(2'd1, 16'd200, 32'hE000_0000, 32'h2000_0000, 31'd1073742,
                    32'hF333_3333, 32'd41875931, 24'hFF_FFFF);
        send_pixel(12'd500, 12'd500);
        send_pixel(12'd250, 12'd700);
        settle();

        // zero limit: everything counts as inside
        load_config(2'd0, 16'd0, 32'hE000_0000, 32'h2000_0000, 31'd1073742,
                    32'hF333_3333, 32'd41875931, 24'hFF_FFFF);
        send_pixel(12'd500, 12'd500);
        send_pixel(12'd0, 12'd0);
        settle();

        load_config(2'd0, 16'd1, 32'hE000_0000, 32'h2000_0000, 31'd1073742,
                    32'hF333_3333, 32'd41875931, 24'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd500, 12'd500);
        settle();

        // extreme registers, start points pinned at the rails
        load_config(2'd3, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        settle();

        load_config(2'd2, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 24'h12_3456);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        settle();

        // origin stays put for the whole limit
        load_config(2'd0, 16'hFFFF, 32'd0, 32'd0, 31'd0, 32'd0, 32'd0, 24'hFF_FFFF);
        send_pixel(12'd7, 12'd9);
        settle();

        // new x overflows inside the loop
        load_config(2'd1, 16'd16, 32'd510027366, 32'd0, 31'd0,
                    32'h7FFF_FFFF, 32'h8000_0000, 24'hA5_5A3C);
        send_pixel(12'd1, 12'd2);
        settle();

        sent = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS)
        begin
            kind = $urandom_range(0, 9);
            ctl  = $urandom_range(0, 3);
            gns  = $urandom;
            jre  = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
            jim  = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
            if (kind == 0)
            begin
                lim  = $urandom_range(0, 64);
                ore  = $urandom;
                oim  = $urandom;
                stp  = $urandom;
                jre  = $urandom;
                jim  = $urandom;
                span = 4096;
            end
            else
            begin
                // a window over the interesting part of the plane
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    lim = $urandom_range(1, 40);
                else if (pick < 18)
                    lim = $urandom_range(41, 200);
                else
                    lim = $urandom_range(1, 3);
                span = 1 << $urandom_range(4, 12);
                ore  = -603979776 + $urandom_range(0, Q_ONE / 2) - Q_ONE / 4;
                oim  = 402653184 + $urandom_range(0, Q_ONE / 2) - Q_ONE / 4;
                stp  = 805306368 / span;
                stp  = stp + $urandom_range(0, stp / 4) - stp / 8;
            end
            if (phase == 3)
                lim = $urandom_range(1, 24);
            quiet = ($urandom_range(0, 3) == 0);
            load_config(ctl, lim, ore, oim, stp, jre, jim, gns);
            // long output stall while input keeps coming
            if (phase == 3)
                hold_req = 1'b1;
            count = $urandom_range(20, 80);
            repeat (count)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    col = $urandom;
                    row = $urandom;
                end
                else
                begin
                    col = $urandom_range(0, span - 1);
                    row = $urandom_range(0, span - 1);
                end
                send_pixel(col, row);
                sent++;
            end
            settle();
            phase++;
        end

        quiet = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pixels_pending == 0)
            $display("escape_time_fractal_pixel_top test passed");
        else
            $display("escape_time_fractal_pixel_top test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/etf_pkg.sv
sv/etf_cfg.sv
sv/etf_mul.sv
sv/etf_div.sv
sv/escape_time_fractal_pixel_top.sv
test/escape_time_fractal_pixel_checker.sv
test/escape_time_fractal_pixel_top_tb.sv
